@@ src/atan_pkg.sv @@
// Shared types and constants for the atan2 polynomial approximation block.
// Used by atan_div_cell, atan_poly and atan2_poly_approx; no dependencies.
package atan_pkg;

   // Ratio a is unsigned Q1.15; internal polynomial values are unsigned Q.30
   localparam int A_FRAC   = 15;
   localparam int Q_FRAC   = 30;
   localparam int QUO_BITS = A_FRAC + 1;

   localparam logic [25:0] C3_MAG  = 26'd49925210;
   localparam logic [27:0] C2_VAL  = 28'd171062341;
   localparam logic [28:0] C1_VAL  = 29'd351782264;
   localparam logic [30:0] HALF_PI = 31'd1686629713;
   localparam logic [31:0] PI_Q    = 32'd3373259426;

   typedef struct packed {
      logic zero;   // both coordinates zero
      logic swap;   // |y| > |x|: reflect about pi/4
      logic xneg;
      logic yneg;
   } flags_type;

endpackage

@@ src/atan_div_cell.sv @@
// One cell of the restoring divider chain: settles one quotient bit per cycle.
// Depends on atan_pkg.
module atan_div_cell #(
   parameter int COORD_WIDTH = 16,
   parameter int BIT         = 15
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  atan_pkg::flags_type                         in_flags,
   input  logic [COORD_WIDTH+atan_pkg::A_FRAC:0]       in_rem,
   input  logic [COORD_WIDTH-1:0]                      in_div,
   input  logic [atan_pkg::QUO_BITS-1:0]               in_quo,
   output logic                                        out_valid,
   output atan_pkg::flags_type                         out_flags,
   output logic [COORD_WIDTH+atan_pkg::A_FRAC:0]       out_rem,
   output logic [COORD_WIDTH-1:0]                      out_div,
   output logic [atan_pkg::QUO_BITS-1:0]               out_quo
);
   import atan_pkg::*;

   localparam int DW = COORD_WIDTH + A_FRAC + 1;

   logic                valid_ff;
   flags_type           flags_ff;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [COORD_WIDTH-1:0] div_ff;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [DW-1:0]       shifted;
   logic [DW:0]         diff;

   always_comb begin
      shifted = DW'(in_div) << BIT;
      diff    = {1'b0, in_rem} - {1'b0, shifted};
      quo_in  = in_quo;
      if (!diff[DW]) begin
         rem_in      = diff[DW-1:0];
         quo_in[BIT] = 1'b1;
      end else begin
         rem_in = in_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      flags_ff <= in_flags;
      rem_ff   <= rem_in;
      div_ff   <= in_div;
      quo_ff   <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;

endmodule

@@ src/atan_poly.sv @@
// Polynomial evaluation, octant/quadrant reflection and final rounding.
// Five register stages; depends on atan_pkg.
module atan_poly #(
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  atan_pkg::flags_type                 in_flags,
   input  logic [atan_pkg::QUO_BITS-1:0]       in_ratio,
   output logic                                out_valid,
   output logic signed [ANGLE_FRAC_BITS+2:0]   out_angle
);
   import atan_pkg::*;

   localparam int AW = ANGLE_FRAC_BITS + 3;
   localparam int SH = Q_FRAC - ANGLE_FRAC_BITS;

   logic [4:0]          valid_ff;
   flags_type           f1_ff, f2_ff, f3_ff, f4_ff;
   logic [15:0]         a1_ff, a2_ff, a3_ff;
   logic [30:0]         s1_ff, s2_ff;
   logic [27:0]         t2_ff, t2_in;
   logic [30:0]         q2_ff, q2_in, q3_ff;
   logic [28:0]         m3_ff, m3_in;
   logic [30:0]         r4_ff, r4_in;
   logic [AW-1:0]       ang_ff, ang_in;

   logic [56:0]         p3;
   logic [46:0]         pas;
   logic [58:0]         pts;
   logic [59:0]         pqm;
   logic [30:0]         rr;
   logic [31:0]         rx;
   logic [32:0]         rnd;
   logic [AW-1:0]       mag;

   always_comb begin
      p3    = 57'(C3_MAG) * 57'(s1_ff);
      t2_in = C2_VAL - 28'((p3 + (57'(1) << (Q_FRAC - 1))) >> Q_FRAC);
      pas   = 47'(a1_ff) * 47'(s1_ff);
      q2_in = 31'((pas + (47'(1) << (A_FRAC - 1))) >> A_FRAC);

      pts   = 59'(t2_ff) * 59'(s2_ff);
      m3_in = C1_VAL - 29'((pts + (59'(1) << (Q_FRAC - 1))) >> Q_FRAC);

      pqm   = 60'(q3_ff) * 60'(m3_ff);
      r4_in = {a3_ff[15:0], 15'b0} - 31'((pqm + (60'(1) << (Q_FRAC - 1))) >> Q_FRAC);

      rr    = f4_ff.swap ? HALF_PI - r4_ff : r4_ff;
      rx    = f4_ff.xneg ? PI_Q - {1'b0, rr} : {1'b0, rr};
      rnd   = ({1'b0, rx} + (33'(1) << (SH - 1))) >> SH;
      mag   = AW'(rnd);
      if (f4_ff.zero) begin
         ang_in = '0;
      end else if (f4_ff.yneg) begin
         ang_in = AW'(0) - mag;
      end else begin
         ang_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
      f1_ff  <= in_flags;
      a1_ff  <= in_ratio;
      s1_ff  <= 31'(in_ratio) * 31'(in_ratio);
      f2_ff  <= f1_ff;
      a2_ff  <= a1_ff;
      s2_ff  <= s1_ff;
      t2_ff  <= t2_in;
      q2_ff  <= q2_in;
      f3_ff  <= f2_ff;
      a3_ff  <= a2_ff;
      q3_ff  <= q2_ff;
      m3_ff  <= m3_in;
      f4_ff  <= f3_ff;
      r4_ff  <= r4_in;
      ang_ff <= ang_in;
   end

   assign out_valid = valid_ff[4];
   assign out_angle = ang_ff;

endmodule

@@ src/atan2_poly_approx.sv @@
// Top level of the atan2 polynomial approximation block.
// Depends on atan_pkg, atan_div_cell and atan_poly.
//
// Takes one (x, y) transaction every clock cycle and returns its angle in
// radians with ANGLE_FRAC_BITS fractional bits, through one magnitude stage,
// a chain of 16 divider cells (one quotient bit each) that forms the ratio of
// the smaller to the larger magnitude, and five stages of polynomial,
// reflection and rounding. busy is always low; every transaction yields
// exactly one rsp_valid pulse, in order, and the receiver must take it.
module atan2_poly_approx #(
   parameter int COORD_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_WIDTH-1:0]     req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]     req_y_coord,
   output logic                              rsp_valid,
   output logic signed [ANGLE_FRAC_BITS+2:0] rsp_angle
);
   import atan_pkg::*;

   localparam int DW = COORD_WIDTH + A_FRAC + 1;
   localparam int CW = COORD_WIDTH;

   logic [CW-1:0]  ax, ay, hi, lo;
   flags_type      flags_in;

   logic                valid_c [QUO_BITS+1];
   flags_type           flags_c [QUO_BITS+1];
   logic [DW-1:0]       rem_c   [QUO_BITS+1];
   logic [CW-1:0]       div_c   [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_c   [QUO_BITS+1];

   logic                valid_ff;
   flags_type           flags_ff;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       div_ff;

   always_comb begin
      ax = req_x_coord[CW-1] ? CW'(~req_x_coord + 1'b1) : CW'(req_x_coord);
      ay = req_y_coord[CW-1] ? CW'(~req_y_coord + 1'b1) : CW'(req_y_coord);
      flags_in.zero = (ax == '0) && (ay == '0);
      flags_in.swap = ay > ax;
      flags_in.xneg = req_x_coord[CW-1];
      flags_in.yneg = req_y_coord[CW-1];
      hi     = flags_in.swap ? ay : ax;
      lo     = flags_in.swap ? ax : ay;
      rem_in = (DW'(lo) << A_FRAC) + DW'(hi >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
      flags_ff <= flags_in;
      rem_ff   <= rem_in;
      div_ff   <= hi;
   end

   assign busy       = 1'b0;
   assign valid_c[0] = valid_ff;
   assign flags_c[0] = flags_ff;
   assign rem_c[0]   = rem_ff;
   assign div_c[0]   = div_ff;
   assign quo_c[0]   = '0;

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
      atan_div_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .BIT        (QUO_BITS - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_c[k]),
         .in_flags (flags_c[k]),
         .in_rem   (rem_c[k]),
         .in_div   (div_c[k]),
         .in_quo   (quo_c[k]),
         .out_valid(valid_c[k+1]),
         .out_flags(flags_c[k+1]),
         .out_rem  (rem_c[k+1]),
         .out_div  (div_c[k+1]),
         .out_quo  (quo_c[k+1])
      );
   end

   atan_poly #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_poly (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_c[QUO_BITS]),
      .in_flags (flags_c[QUO_BITS]),
      .in_ratio (quo_c[QUO_BITS]),
      .out_valid(rsp_valid),
      .out_angle(rsp_angle)
   );

`ifndef SYNTHESIS
   localparam logic [32:0] ANGLE_MAX =
      ({1'b0, PI_Q} + (33'(1) << (Q_FRAC - ANGLE_FRAC_BITS - 1)))
      >> (Q_FRAC - ANGLE_FRAC_BITS);

   a_result_follows_divider: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(valid_c[QUO_BITS], 5))
      else $error("result strobe without a divider output five cycles earlier");

   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_angle <= $signed(ANGLE_MAX[ANGLE_FRAC_BITS+2:0]))
                  && (rsp_angle >= -$signed(ANGLE_MAX[ANGLE_FRAC_BITS+2:0]))))
      else $error("angle outside -pi..pi");

   a_ratio_bounded: assert property (@(posedge clock) disable iff (reset)
      (valid_c[QUO_BITS] && !flags_c[QUO_BITS].zero) |->
         (quo_c[QUO_BITS] <= (QUO_BITS'(1) << A_FRAC)))
      else $error("divider ratio above one");
`endif

endmodule
